@@ rtl/core/qte_pkg.sv @@
// qte_pkg: shared constants, types and helper functions for the quaternion
// to euler angle core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

  // fixed formats
  localparam int COMPONENT_WIDTH = 16;
  localparam int CORDIC_STEPS    = 16;
  localparam int FRAC            = 30;
  localparam int PROD_W          = 2 * COMPONENT_WIDTH;
  localparam int PROD_SHIFT      = FRAC - 2 * (COMPONENT_WIDTH - 2);
  localparam int SW              = 37;   // product sums, q30
  localparam int TW              = 31;   // unclamped pitch argument, q30
  localparam int CW              = 40;   // cordic x / y
  localparam int ZW              = 34;   // cordic angle, q30
  localparam int SQW             = 64;   // square root working width
  localparam int SQ_STEPS        = 32;
  localparam int QDEPTH          = 4;
  localparam int QAW             = 2;
  localparam int RND_SHIFT       = FRAC - 13;
  localparam int ROUND_ADD       = 1 << (FRAC - 14);
  localparam int HALF_PI_Q30     = 1686629713;
  localparam int PI_Q13          = 25736;
  localparam int HALF_PI_Q13     = 12868;

  // pitch argument class
  typedef enum logic [1:0] {
    PCLS_MID,
    PCLS_POS,
    PCLS_NEG
  } pcls_t;

  // one classified transaction between front and back
  typedef struct packed {
    logic signed [SW-1:0] r0;
    logic signed [SW-1:0] r1;
    logic signed [SW-1:0] y0;
    logic signed [SW-1:0] y1;
    logic signed [TW-1:0] t;
    pcls_t                pcls;
  } qte_item_t;

  // arctangent table, q30
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
      3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
      6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
      9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
      18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
      21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
      24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
      27: v = 32'h00000008; 28: v = 32'h00000004; 29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return ZW'(v);
  endfunction

  // round half up to q13 and clamp to +-lim
  function automatic logic signed [15:0] sat_q13(input logic signed [ZW-1:0] z,
                                                 input logic signed [ZW-1:0] lim);
    logic signed [ZW-1:0] r;
    r = (z + ZW'(ROUND_ADD)) >>> RND_SHIFT;
    if (r > lim) r = lim;
    else if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/qte_front.sv @@
// qte_front: accepts quaternions, forms the component products and the
// product sums, classifies the pitch argument. Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_front import qte_pkg::*; (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              accept,
  input  wire logic signed [COMPONENT_WIDTH-1:0] quat_w,
  input  wire logic signed [COMPONENT_WIDTH-1:0] quat_x,
  input  wire logic signed [COMPONENT_WIDTH-1:0] quat_y,
  input  wire logic signed [COMPONENT_WIDTH-1:0] quat_z,
  output logic                                   push,
  output qte_item_t                              push_item
);

  logic                     p_valid_r;
  logic signed [PROD_W-1:0] ww_r, xx_r, yy_r, zz_r, yz_r, wx_r, xy_r, wz_r, wy_r, xz_r;
  logic                     push_r;
  qte_item_t                item_r, item_nxt;

  // stage one: component products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= accept;
    end
    ww_r <= quat_w * quat_w;
    xx_r <= quat_x * quat_x;
    yy_r <= quat_y * quat_y;
    zz_r <= quat_z * quat_z;
    yz_r <= quat_y * quat_z;
    wx_r <= quat_w * quat_x;
    xy_r <= quat_x * quat_y;
    wz_r <= quat_w * quat_z;
    wy_r <= quat_w * quat_y;
    xz_r <= quat_x * quat_z;
  end

  // stage two: sums in q30 and pitch class
  always_comb begin
    logic signed [SW-1:0] tt;
    logic signed [SW-1:0] one;
    one = SW'(1) <<< FRAC;
    item_nxt.r0 = (SW'(yz_r) + SW'(wx_r)) <<< (PROD_SHIFT + 1);
    item_nxt.r1 = (SW'(ww_r) - SW'(xx_r) - SW'(yy_r) + SW'(zz_r)) <<< PROD_SHIFT;
    item_nxt.y0 = (SW'(xy_r) + SW'(wz_r)) <<< (PROD_SHIFT + 1);
    item_nxt.y1 = (SW'(ww_r) + SW'(xx_r) - SW'(yy_r) - SW'(zz_r)) <<< PROD_SHIFT;
    tt          = (SW'(wy_r) - SW'(xz_r)) <<< (PROD_SHIFT + 1);
    if (tt >= one) begin
      item_nxt.pcls = PCLS_POS;
      item_nxt.t    = '0;
    end else if (tt <= -one) begin
      item_nxt.pcls = PCLS_NEG;
      item_nxt.t    = '0;
    end else begin
      item_nxt.pcls = PCLS_MID;
      item_nxt.t    = tt[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      push_r <= 1'b0;
    end else begin
      push_r <= p_valid_r;
    end
    item_r <= item_nxt;
  end

  assign push      = push_r;
  assign push_item = item_r;

endmodule
`default_nettype wire

@@ rtl/core/qte_queue.sv @@
// qte_queue: short register queue between front and back.
// Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_queue import qte_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire qte_item_t  push_item,
  input  wire logic       pop,
  output logic            empty,
  output logic [QAW:0]    count,
  output qte_item_t       head
);

  qte_item_t      mem_r [0:QDEPTH-1];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   count_r, count_nxt;
  logic           full;

  assign empty = (count_r == '0);
  assign full  = (count_r == (QAW+1)'(QDEPTH));
  assign count = count_r;
  assign head  = mem_r[rptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop) rptr_r <= rptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("queue underflow");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1)) else $error("count slip");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wptr_r - rptr_r) == count_r[QAW-1:0]) else $error("pointer mismatch");

endmodule
`default_nettype wire

@@ rtl/core/qte_isqrt.sv @@
// qte_isqrt: pipelined exact integer square root, one result bit per stage,
// carrying a transaction alongside. Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_isqrt import qte_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           valid_i,
  input  wire logic [SQW-1:0] v_i,
  input  wire qte_item_t      side_i,
  output logic                valid_o,
  output logic [TW-1:0]       root_o,
  output qte_item_t           side_o
);

  logic           vld_r  [0:SQ_STEPS];
  logic [SQW-1:0] rem_r  [0:SQ_STEPS];
  logic [SQW-1:0] root_r [0:SQ_STEPS];
  qte_item_t      side_r [0:SQ_STEPS];

  assign vld_r[0]  = valid_i;
  assign rem_r[0]  = v_i;
  assign root_r[0] = '0;
  assign side_r[0] = side_i;

  // one restoring step per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [SQW-1:0] trial;
    assign trial = root_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      side_r[k+1] <= side_r[k];
      if (rem_r[k] >= trial) begin
        rem_r[k+1]  <= rem_r[k] - trial;
        root_r[k+1] <= (root_r[k] >> 1) + BIT;
      end else begin
        rem_r[k+1]  <= rem_r[k];
        root_r[k+1] <= root_r[k] >> 1;
      end
    end
  end

  assign valid_o = vld_r[SQ_STEPS];
  assign root_o  = root_r[SQ_STEPS][TW-1:0];
  assign side_o  = side_r[SQ_STEPS];

endmodule
`default_nettype wire

@@ rtl/core/qte_cordic.sv @@
// qte_cordic: pipelined vectoring cordic giving the q30 angle of (x, y).
// Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic import qte_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 valid_i,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic signed [CW-1:0] y_i,
  output logic                      valid_o,
  output logic signed [ZW-1:0]      z_o
);

  logic                 vld_r  [0:CORDIC_STEPS];
  logic                 zero_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] x_r    [0:CORDIC_STEPS];
  logic signed [CW-1:0] y_r    [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z_r    [0:CORDIC_STEPS];

  // quadrant fold into the right half plane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= valid_i;
    end
    zero_r[0] <= (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x_r[0] <= y_i;
        y_r[0] <= -x_i;
        z_r[0] <= ZW'(HALF_PI_Q30);
      end else begin
        x_r[0] <= -y_i;
        y_r[0] <= x_i;
        z_r[0] <= -ZW'(HALF_PI_Q30);
      end
    end else begin
      x_r[0] <= x_i;
      y_r[0] <= y_i;
      z_r[0] <= '0;
    end
  end

  // micro-rotations
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ANG = atan_q30(i);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      zero_r[i+1] <= zero_r[i];
      if (y_r[i] > 0) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ANG;
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ANG;
      end
    end
  end

  assign valid_o = vld_r[CORDIC_STEPS];
  assign z_o     = zero_r[CORDIC_STEPS] ? '0 : z_r[CORDIC_STEPS];

endmodule
`default_nettype wire

@@ rtl/core/qte_back.sv @@
// qte_back: pops classified transactions, squares the pitch argument, runs
// the square root and three cordics, rounds and clamps the angles.
// Depends on qte_pkg, qte_isqrt, qte_cordic.
`timescale 1ns / 1ps
`default_nettype none
module qte_back import qte_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      empty,
  input  wire qte_item_t head,
  output logic       pop,
  output logic       out_strobe,
  output logic signed [15:0] out_roll_angle,
  output logic signed [14:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle
);

  logic                   a_valid_r;
  qte_item_t              a_item_r;
  logic [2*TW-1:0]        a_sq_r;
  logic [SQW-1:0]         rest;
  logic                   s_valid;
  logic [TW-1:0]          s_root;
  qte_item_t              s_item;
  logic                   roll_v, pitch_v, yaw_v;
  logic signed [ZW-1:0]   roll_z, pitch_z, yaw_z;
  pcls_t                  pc_r [0:CORDIC_STEPS];
  logic                   o_strobe_r;
  logic signed [15:0]     o_roll_r, o_yaw_r;
  logic signed [14:0]     o_pitch_r;
  logic signed [15:0]     pitch_sat;

  // the back never stalls
  assign pop = !empty;

  // square of the pitch argument
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= pop;
    end
    a_item_r <= head;
    a_sq_r   <= (2*TW)'(head.t * head.t);
  end

  assign rest = (SQW'(1) << (2 * FRAC)) - SQW'(a_sq_r);

  qte_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (a_valid_r),
    .v_i     (rest),
    .side_i  (a_item_r),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_item)
  );

  qte_cordic u_roll (
    .clk (clk), .rst_n (rst_n), .valid_i (s_valid),
    .x_i (CW'(s_item.r1)), .y_i (CW'(s_item.r0)),
    .valid_o (roll_v), .z_o (roll_z)
  );

  qte_cordic u_pitch (
    .clk (clk), .rst_n (rst_n), .valid_i (s_valid),
    .x_i (CW'({1'b0, s_root})), .y_i (CW'(s_item.t)),
    .valid_o (pitch_v), .z_o (pitch_z)
  );

  qte_cordic u_yaw (
    .clk (clk), .rst_n (rst_n), .valid_i (s_valid),
    .x_i (CW'(s_item.y1)), .y_i (CW'(s_item.y0)),
    .valid_o (yaw_v), .z_o (yaw_z)
  );

  // pitch class follows the cordic latency
  always_ff @(posedge clk) begin
    pc_r[0] <= s_item.pcls;
  end
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_pc
    always_ff @(posedge clk) begin
      pc_r[i+1] <= pc_r[i];
    end
  end

  // pitch clamp selection
  always_comb begin
    case (pc_r[CORDIC_STEPS])
      PCLS_POS: pitch_sat = 16'(HALF_PI_Q13);
      PCLS_NEG: pitch_sat = -16'(HALF_PI_Q13);
      default:  pitch_sat = sat_q13(pitch_z, ZW'(HALF_PI_Q13));
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_strobe_r <= 1'b0;
    end else begin
      o_strobe_r <= roll_v;
    end
    o_roll_r  <= sat_q13(roll_z, ZW'(PI_Q13));
    o_yaw_r   <= sat_q13(yaw_z, ZW'(PI_Q13));
    o_pitch_r <= pitch_sat[14:0];
  end

  assign out_strobe      = o_strobe_r;
  assign out_roll_angle  = o_roll_r;
  assign out_pitch_angle = o_pitch_r;
  assign out_yaw_angle   = o_yaw_r;

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (roll_v == pitch_v) && (roll_v == yaw_v)) else $error("cordic lanes out of step");
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(roll_v)) else $error("strobe without cordic result");
  a_pitch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_pitch_angle <= 15'sd12868 && out_pitch_angle >= -15'sd12868))
    else $error("pitch out of range");

endmodule
`default_nettype wire

@@ rtl/core/quaternion_to_euler_angles_core.sv @@
// quaternion_to_euler_angles_core: top level, front, queue and back.
// Depends on qte_pkg, qte_front, qte_queue, qte_back.
//
// channel   direction  ports                                   handshake
// input     in         in_quat_w/x/y/z (s16 q2.14)              start & !busy
// result    out        out_roll_angle, out_yaw_angle (s16 q3.13),
//                      out_pitch_angle (s15 q2.13)              out_strobe
//
// one quaternion per cycle while busy is low; each result passes from its
// accept through the 32-stage square root pipeline and the 17-stage cordics.
// reset is synchronous, active low; it clears the valid flags and the queue.
// busy rises only when the front/back queue runs short of room.
// the receiver cannot stall: each result is shown for one cycle under out_strobe.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles_core import qte_pkg::*; (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [COMPONENT_WIDTH-1:0] in_quat_w,
  input  wire logic signed [COMPONENT_WIDTH-1:0] in_quat_x,
  input  wire logic signed [COMPONENT_WIDTH-1:0] in_quat_y,
  input  wire logic signed [COMPONENT_WIDTH-1:0] in_quat_z,
  output logic                                   out_strobe,
  output logic signed [15:0]                     out_roll_angle,
  output logic signed [14:0]                     out_pitch_angle,
  output logic signed [15:0]                     out_yaw_angle
);

  logic         accept;
  logic         push, pop, empty;
  qte_item_t    push_item, head;
  logic [QAW:0] count;

  // leave room for the two front stages in flight
  assign busy   = (count >= (QAW+1)'(QDEPTH - 2));
  assign accept = start && !busy;

  qte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .quat_w    (in_quat_w),
    .quat_x    (in_quat_x),
    .quat_y    (in_quat_y),
    .quat_z    (in_quat_z),
    .push      (push),
    .push_item (push_item)
  );

  qte_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .empty     (empty),
    .count     (count),
    .head      (head)
  );

  qte_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty           (empty),
    .head            (head),
    .pop             (pop),
    .out_strobe      (out_strobe),
    .out_roll_angle  (out_roll_angle),
    .out_pitch_angle (out_pitch_angle),
    .out_yaw_angle   (out_yaw_angle)
  );

endmodule
`default_nettype wire
